@@ sv/assert_macros.svh @@
// Assertion helpers; clk and rst_n are taken from the enclosing module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define IUS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IUS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ius_pkg.sv @@
package ius_pkg;

    localparam int CAPACITY_DEF  = 16;
    localparam int POS_WIDTH_DEF = 32;
    localparam int FIELD_W       = 32;
    localparam int COUNT_W       = 5;

    localparam logic [1:0] ACT_ADD   = 2'd0;
    localparam logic [1:0] ACT_QUERY = 2'd1;
    localparam logic [1:0] ACT_COMP  = 2'd2;

    typedef struct packed {
        logic [1:0]         action;
        logic [FIELD_W-1:0] range_lo;
        logic [FIELD_W-1:0] range_hi;
    } item_t;

    typedef struct packed {
        logic               overlaps;
        logic [FIELD_W-1:0] gap_lo;
        logic [FIELD_W-1:0] gap_hi;
        logic               gap_none;
        logic               last_result;
        logic [COUNT_W-1:0] segment_count;
        logic               add_dropped;
    } result_t;

    // Compare results of a segment (start s, end e) against two references a, b.
    typedef struct packed {
        logic s_lt_a;
        logic s_gt_a;
        logic s_lt_b;
        logic s_gt_b;
        logic e_lt_a;
        logic e_gt_a;
        logic e_gt_b;
    } cmp_flags_t;

endpackage

@@ sv/ius_seg_mem.sv @@
module ius_seg_mem #(
    parameter int DEPTH = ius_pkg::CAPACITY_DEF,
    parameter int WIDTH = ius_pkg::POS_WIDTH_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wstart,
    input  logic [WIDTH-1:0]         wend,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rstart,
    output logic [WIDTH-1:0]         rend
);

    logic [WIDTH-1:0] start_mem_reg [DEPTH];
    logic [WIDTH-1:0] end_mem_reg   [DEPTH];
    logic [WIDTH-1:0] rstart_reg;
    logic [WIDTH-1:0] rend_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            start_mem_reg[waddr] <= wstart;
            end_mem_reg[waddr]   <= wend;
        end
        rstart_reg <= start_mem_reg[raddr];
        rend_reg   <= end_mem_reg[raddr];
    end

    assign rstart = rstart_reg;
    assign rend   = rend_reg;

endmodule

@@ sv/ius_cmp.sv @@
module ius_cmp #(
    parameter int WIDTH = ius_pkg::POS_WIDTH_DEF
) (
    input  logic [WIDTH-1:0]  seg_start,
    input  logic [WIDTH-1:0]  seg_end,
    input  logic [WIDTH-1:0]  ref_a,
    input  logic [WIDTH-1:0]  ref_b,
    output ius_pkg::cmp_flags_t flags
);

    always_comb
    begin
        flags.s_lt_a = seg_start < ref_a;
        flags.s_gt_a = seg_start > ref_a;
        flags.s_lt_b = seg_start < ref_b;
        flags.s_gt_b = seg_start > ref_b;
        flags.e_lt_a = seg_end < ref_a;
        flags.e_gt_a = seg_end > ref_a;
        flags.e_gt_b = seg_end > ref_b;
    end

endmodule

@@ sv/interval_union_set.sv @@
// channel  | handshake                  | payload
// ---------+----------------------------+------------------
// item     | item_valid / item_ready    | ius_pkg::item_t
// result   | result_valid / result_ready| ius_pkg::result_t
//
// At most one stored segment per cycle (fewer while the output stalls) goes through the single compare unit, fed by the
// one read port of the segment store; N is the current segment count.
// add: a scan pass over the store, then a rebuild pass unless the add is dropped, then the result.
// query: scans until the first overlap; complement: scans the store, then the tail, and waits on any output stall.
// rst_n clears count and control; store contents are unknown until written.
// Results sit in an output register; a new item is taken while one still waits.
`include "assert_macros.svh"

module interval_union_set #(
    parameter int CAPACITY       = ius_pkg::CAPACITY_DEF,
    parameter int POSITION_WIDTH = ius_pkg::POS_WIDTH_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  ius_pkg::item_t   item,
    output logic             result_valid,
    input  logic             result_ready,
    output ius_pkg::result_t result
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IW   = $clog2(CAPACITY);
    localparam int PW   = POSITION_WIDTH;
    localparam int FW   = ius_pkg::FIELD_W;
    localparam int CNTW = ius_pkg::COUNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_BUILD,
        ST_QUERY,
        ST_COMP,
        ST_TAIL,
        ST_FINISH
    } state_t;

    state_t            state_reg, state_next;
    logic [1:0]        action_reg, action_next;
    logic [PW-1:0]     lo_reg, lo_next;
    logic [PW-1:0]     hi_reg, hi_next;
    logic [PW-1:0]     mlo_reg, mlo_next;
    logic [PW-1:0]     mhi_reg, mhi_next;
    logic [PW-1:0]     prev_reg, prev_next;
    logic              merged_reg, merged_next;
    logic              placed_reg, placed_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     n_reg, n_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [PW-1:0]     pend_lo_reg, pend_lo_next;
    logic [PW-1:0]     pend_hi_reg, pend_hi_next;
    logic              overlap_reg, overlap_next;
    logic              dropped_reg, dropped_next;
    logic              result_valid_reg, result_valid_next;
    ius_pkg::result_t  result_reg, result_next;

    logic [PW-1:0]     lo_in, hi_in;
    logic [PW-1:0]     rd_start, rd_end;
    logic [PW-1:0]     cmp_s, cmp_a, cmp_b;
    ius_pkg::cmp_flags_t flags;
    logic              mem_we;
    logic [PW-1:0]     wr_start, wr_end;
    logic              out_free;
    logic [CW-1:0]     idx_inc, n_inc;
    logic              at_end;

    assign lo_in   = PW'(item.range_lo);
    assign hi_in   = PW'(item.range_hi);
    assign idx_inc = CW'(idx_reg + 1'b1);
    assign n_inc   = CW'(n_reg + 1'b1);
    assign at_end  = (idx_reg == count_reg);
    assign out_free = !result_valid_reg || result_ready;

    ius_seg_mem #(
        .DEPTH (CAPACITY),
        .WIDTH (PW)
    ) u_mem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (n_reg[IW-1:0]),
        .wstart (wr_start),
        .wend   (wr_end),
        .raddr  (idx_next[IW-1:0]),
        .rstart (rd_start),
        .rend   (rd_end)
    );

    // operand select for the shared compare unit
    always_comb
    begin
        case (state_reg)
            ST_IDLE:  cmp_s = lo_in;
            ST_TAIL:  cmp_s = prev_reg;
            default:  cmp_s = rd_start;
        endcase
        case (state_reg)
            ST_BUILD: cmp_a = mlo_reg;
            ST_COMP:  cmp_a = prev_reg;
            default:  cmp_a = lo_reg;
        endcase
        case (state_reg)
            ST_IDLE:  cmp_b = hi_in;
            ST_BUILD: cmp_b = mhi_reg;
            default:  cmp_b = hi_reg;
        endcase
    end

    ius_cmp #(
        .WIDTH (PW)
    ) u_cmp (
        .seg_start (cmp_s),
        .seg_end   (rd_end),
        .ref_a     (cmp_a),
        .ref_b     (cmp_b),
        .flags     (flags)
    );

    always_comb
    begin
        state_next        = state_reg;
        action_next       = action_reg;
        lo_next           = lo_reg;
        hi_next           = hi_reg;
        mlo_next          = mlo_reg;
        mhi_next          = mhi_reg;
        prev_next         = prev_reg;
        merged_next       = merged_reg;
        placed_next       = placed_reg;
        idx_next          = idx_reg;
        n_next            = n_reg;
        count_next        = count_reg;
        pend_valid_next   = pend_valid_reg;
        pend_lo_next      = pend_lo_reg;
        pend_hi_next      = pend_hi_reg;
        overlap_next      = overlap_reg;
        dropped_next      = dropped_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        mem_we            = 1'b0;
        wr_start          = mlo_reg;
        wr_end            = mhi_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    action_next     = item.action;
                    lo_next         = lo_in;
                    hi_next         = hi_in;
                    mlo_next        = lo_in;
                    mhi_next        = hi_in;
                    prev_next       = lo_in;
                    idx_next        = '0;
                    n_next          = '0;
                    merged_next     = 1'b0;
                    placed_next     = 1'b0;
                    pend_valid_next = 1'b0;
                    overlap_next    = 1'b0;
                    dropped_next    = 1'b0;
                    // empty range goes straight to the single result
                    case (item.action)
                        ius_pkg::ACT_ADD:   state_next = flags.s_lt_b ? ST_SCAN : ST_FINISH;
                        ius_pkg::ACT_QUERY: state_next = flags.s_lt_b ? ST_QUERY : ST_FINISH;
                        ius_pkg::ACT_COMP:  state_next = flags.s_lt_b ? ST_COMP : ST_FINISH;
                        default:            state_next = ST_FINISH;
                    endcase
                end
            end

            ST_SCAN:
            begin
                if (!at_end)
                begin
                    // touch or overlap; only the first merged start can lie below lo,
                    // only the last merged end above hi
                    if (!flags.s_gt_b && !flags.e_lt_a)
                    begin
                        merged_next = 1'b1;
                        if (flags.s_lt_a)
                            mlo_next = rd_start;
                        if (flags.e_gt_b)
                            mhi_next = rd_end;
                    end
                    idx_next = idx_inc;
                end
                else if (!merged_reg && count_reg == CW'(CAPACITY))
                begin
                    dropped_next = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    idx_next   = '0;
                    n_next     = '0;
                    state_next = ST_BUILD;
                end
            end

            ST_BUILD:
            begin
                if (!at_end)
                begin
                    if (flags.s_gt_b && !placed_reg)
                    begin
                        // insert merged segment, revisit this entry next cycle
                        mem_we      = 1'b1;
                        n_next      = n_inc;
                        placed_next = 1'b1;
                    end
                    else
                    begin
                        if (flags.e_lt_a || flags.s_gt_b)
                        begin
                            mem_we   = 1'b1;
                            wr_start = rd_start;
                            wr_end   = rd_end;
                            n_next   = n_inc;
                        end
                        idx_next = idx_inc;
                    end
                end
                else
                begin
                    if (!placed_reg)
                    begin
                        mem_we     = 1'b1;
                        count_next = n_inc;
                    end
                    else
                    begin
                        count_next = n_reg;
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_QUERY:
            begin
                if (at_end)
                begin
                    state_next = ST_FINISH;
                end
                else if (flags.s_lt_b && flags.e_gt_a)
                begin
                    overlap_next = 1'b1;
                    state_next   = ST_FINISH;
                end
                else
                begin
                    idx_next = idx_inc;
                end
            end

            ST_COMP:
            begin
                if (at_end || !flags.s_lt_b)
                begin
                    state_next = ST_TAIL;
                end
                else if (!flags.e_gt_a)
                begin
                    idx_next = idx_inc;
                end
                else if (!flags.s_gt_a)
                begin
                    prev_next = rd_end;
                    idx_next  = idx_inc;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    // new gap; the one held back is known not to be last
                    if (pend_valid_reg)
                    begin
                        result_valid_next = 1'b1;
                        result_next = '{overlaps: 1'b0, gap_lo: FW'(pend_lo_reg),
                                        gap_hi: FW'(pend_hi_reg), gap_none: 1'b0,
                                        last_result: 1'b0,
                                        segment_count: CNTW'(count_reg),
                                        add_dropped: 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_lo_next    = prev_reg;
                    pend_hi_next    = rd_start;
                    prev_next       = rd_end;
                    idx_next        = idx_inc;
                end
            end

            ST_TAIL:
            begin
                if (!flags.s_lt_b)
                begin
                    state_next = ST_FINISH;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        result_valid_next = 1'b1;
                        result_next = '{overlaps: 1'b0, gap_lo: FW'(pend_lo_reg),
                                        gap_hi: FW'(pend_hi_reg), gap_none: 1'b0,
                                        last_result: 1'b0,
                                        segment_count: CNTW'(count_reg),
                                        add_dropped: 1'b0};
                    end
                    pend_valid_next = 1'b1;
                    pend_lo_next    = prev_reg;
                    pend_hi_next    = hi_reg;
                    prev_next       = hi_reg;
                end
            end

            ST_FINISH:
            begin
                if (out_free)
                begin
                    result_valid_next = 1'b1;
                    result_next = '{overlaps: overlap_reg,
                                    gap_lo: pend_valid_reg ? FW'(pend_lo_reg) : '0,
                                    gap_hi: pend_valid_reg ? FW'(pend_hi_reg) : '0,
                                    gap_none: (action_reg == ius_pkg::ACT_COMP)
                                              && !pend_valid_reg,
                                    last_result: 1'b1,
                                    segment_count: CNTW'(count_reg),
                                    add_dropped: dropped_reg};
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
            pend_valid_reg   <= 1'b0;
            merged_reg       <= 1'b0;
            placed_reg       <= 1'b0;
            idx_reg          <= '0;
            n_reg            <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
            pend_valid_reg   <= pend_valid_next;
            merged_reg       <= merged_next;
            placed_reg       <= placed_next;
            idx_reg          <= idx_next;
            n_reg            <= n_next;
        end
    end

    always_ff @(posedge clk)
    begin
        action_reg   <= action_next;
        lo_reg       <= lo_next;
        hi_reg       <= hi_next;
        mlo_reg      <= mlo_next;
        mhi_reg      <= mhi_next;
        prev_reg     <= prev_next;
        pend_lo_reg  <= pend_lo_next;
        pend_hi_reg  <= pend_hi_next;
        overlap_reg  <= overlap_next;
        dropped_reg  <= dropped_next;
        result_reg   <= result_next;
    end

    assign item_ready   = (state_reg == ST_IDLE);
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    `IUS_ASSERT(a_count_cap, 1'b1, count_reg <= CW'(CAPACITY), "segment count above capacity")
    `IUS_ASSERT(a_wr_lag, mem_we, (n_reg <= idx_reg) || (n_reg == idx_inc), "rebuild write ahead of read")
    `IUS_ASSERT(a_none_last, result_valid_reg && result_reg.gap_none, result_reg.last_result && (result_reg.gap_lo == '0) && (result_reg.gap_hi == '0), "empty complement beat malformed")
    `IUS_ASSERT_NEXT(a_finish_hold, (state_reg == ST_FINISH) && !out_free, (state_reg == ST_FINISH) && result_valid_reg, "final beat lost while output busy")

endmodule

@@ test/tb.sv @@
module tb;

    localparam int         CAPACITY     = ius_pkg::CAPACITY_DEF;
    localparam int         FIELD_W      = ius_pkg::FIELD_W;
    localparam int         COUNT_W      = ius_pkg::COUNT_W;
    localparam logic [1:0] ACT_NOP      = 2'd3;
    localparam int         QUIET_LIMIT  = 1000;
    localparam int         DRAIN_CYCLES = 60;
    localparam int         PRINT_LIMIT  = 40;

    logic             clk;
    logic             rst_n;
    logic             item_valid;
    logic             item_ready;
    ius_pkg::item_t   item;
    logic             result_valid;
    logic             result_ready;
    ius_pkg::result_t result;

    interval_union_set i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // predicted segment store
    logic [FIELD_W-1:0] seg_lo [CAPACITY];
    logic [FIELD_W-1:0] seg_hi [CAPACITY];
    int                 seg_n;

    ius_pkg::result_t pending_results[$];

    int mismatches;
    int items_sent;
    int results_seen;
    int drops_seen;
    int max_gaps;
    int quiet_cycles;

    // sender / receiver pacing
    bit idle_on;
    int burst_left;
    int stall_mode;
    int stall_phase;

    always #10 clk = ~clk;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch %s: got %0h want %0h (result %0d)", what, got, want,
                     results_seen);
        mismatches++;
    endtask

    function automatic void enqueue_result(ius_pkg::result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    function automatic ius_pkg::result_t make_result(logic ov, logic [FIELD_W-1:0] glo,
                                                     logic [FIELD_W-1:0] ghi, logic none,
                                                     logic last, logic dropped);
        ius_pkg::result_t r;
        r.overlaps      = ov;
        r.gap_lo        = glo;
        r.gap_hi        = ghi;
        r.gap_none      = none;
        r.last_result   = last;
        r.segment_count = COUNT_W'(seg_n);
        r.add_dropped   = dropped;
        return r;
    endfunction

    // Insert [lo,hi), folding in every segment that overlaps or touches it.
    function automatic bit union_add(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
        logic [FIELD_W-1:0] ns [CAPACITY];
        logic [FIELD_W-1:0] ne [CAPACITY];
        logic [FIELD_W-1:0] mlo, mhi;
        bit merged, placed;
        int n;
        merged = 1'b0;
        placed = 1'b0;
        n      = 0;
        mlo    = lo;
        mhi    = hi;
        if (hi <= lo)
            return 1'b0;
        for (int i = 0; i < seg_n; i++)
        begin
            if (seg_lo[i] <= hi && seg_hi[i] >= lo)
            begin
                merged = 1'b1;
                if (seg_lo[i] < mlo) mlo = seg_lo[i];
                if (seg_hi[i] > mhi) mhi = seg_hi[i];
            end
        end
        if (!merged && seg_n >= CAPACITY)
            return 1'b1;
        for (int i = 0; i < seg_n && n < CAPACITY; i++)
        begin
            if (seg_hi[i] < mlo || seg_lo[i] > mhi)
            begin
                if (seg_lo[i] > mhi && !placed && n < CAPACITY)
                begin
                    ns[n] = mlo;
                    ne[n] = mhi;
                    n++;
                    placed = 1'b1;
                end
                if (n < CAPACITY)
                begin
                    ns[n] = seg_lo[i];
                    ne[n] = seg_hi[i];
                    n++;
                end
            end
        end
        if (!placed && n < CAPACITY)
        begin
            ns[n] = mlo;
            ne[n] = mhi;
            n++;
        end
        for (int i = 0; i < n; i++)
        begin
            seg_lo[i] = ns[i];
            seg_hi[i] = ne[i];
        end
        seg_n = n;
        return 1'b0;
    endfunction

    function automatic bit union_hits(logic [FIELD_W-1:0] lo, logic [FIELD_W-1:0] hi);
        if (hi <= lo)
            return 1'b0;
        for (int i = 0; i < seg_n; i++)
            if (seg_lo[i] < hi && seg_hi[i] > lo)
                return 1'b1;
        return 1'b0;
    endfunction

    // Queue the gaps of the union inside [lo,hi), clipped to the window.
    task automatic queue_gaps(input logic [FIELD_W-1:0] lo, input logic [FIELD_W-1:0] hi);
        ius_pkg::result_t gaps [CAPACITY+1];
        logic [FIELD_W-1:0] prev;
        int k;
        k    = 0;
        prev = lo;
        if (lo < hi)
        begin
            for (int i = 0; i < seg_n && k < CAPACITY + 1; i++)
            begin
                if (seg_lo[i] >= hi)
                    break;
                if (seg_hi[i] <= prev)
                    continue;
                if (seg_lo[i] > prev)
                begin
                    gaps[k] = make_result(1'b0, prev, seg_lo[i], 1'b0, 1'b0, 1'b0);
                    k++;
                end
                prev = seg_hi[i];
            end
            if (prev < hi && k < CAPACITY + 1)
            begin
                gaps[k] = make_result(1'b0, prev, hi, 1'b0, 1'b0, 1'b0);
                k++;
            end
        end
        if (k == 0)
            enqueue_result(make_result(1'b0, '0, '0, 1'b1, 1'b1, 1'b0));
        else
        begin
            gaps[k-1].last_result = 1'b1;
            for (int i = 0; i < k; i++)
                enqueue_result(gaps[i]);
        end
        if (k > max_gaps)
            max_gaps = k;
    endtask

    task automatic predict_results(input ius_pkg::item_t it);
        bit dropped;
        case (it.action)
            ius_pkg::ACT_ADD:
            begin
                dropped = union_add(it.range_lo, it.range_hi);
                if (dropped)
                    drops_seen++;
                enqueue_result(make_result(1'b0, '0, '0, 1'b0, 1'b1, dropped));
            end
            ius_pkg::ACT_QUERY:
                enqueue_result(make_result(union_hits(it.range_lo, it.range_hi),
                                           '0, '0, 1'b0, 1'b1, 1'b0));
            ius_pkg::ACT_COMP:
                queue_gaps(it.range_lo, it.range_hi);
            default:
                enqueue_result(make_result(1'b0, '0, '0, 1'b0, 1'b1, 1'b0));
        endcase
    endtask

    // Called at a clock edge; returns at the edge where the beat is taken.
    task automatic send_item(input logic [1:0] act, input logic [FIELD_W-1:0] lo,
                             input logic [FIELD_W-1:0] hi);
        ius_pkg::item_t it;
        int gap;
        it.action   = act;
        it.range_lo = lo;
        it.range_hi = hi;
        if (idle_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        predict_results(it);
        items_sent++;
    endtask

    always @(posedge clk)
    begin
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            0:       result_ready <= 1'b1;
            1:       result_ready <= (stall_phase % 7) < 4;
            2:       result_ready <= $urandom_range(0, 3) != 0;
            default: result_ready <= (stall_phase % 23) >= 15;
        endcase
    end

    always @(posedge clk)
    begin : check_results
        ius_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
                report("unexpected result beat", result.gap_lo, '0);
            else
            begin
                want = pending_results.pop_front();
                if (result.overlaps !== want.overlaps)
                    report("overlaps", 32'(result.overlaps), 32'(want.overlaps));
                if (result.gap_lo !== want.gap_lo)
                    report("gap_lo", result.gap_lo, want.gap_lo);
                if (result.gap_hi !== want.gap_hi)
                    report("gap_hi", result.gap_hi, want.gap_hi);
                if (result.gap_none !== want.gap_none)
                    report("gap_none", 32'(result.gap_none), 32'(want.gap_none));
                if (result.last_result !== want.last_result)
                    report("last_result", 32'(result.last_result), 32'(want.last_result));
                if (result.segment_count !== want.segment_count)
                    report("segment_count", 32'(result.segment_count),
                           32'(want.segment_count));
                if (result.add_dropped !== want.add_dropped)
                    report("add_dropped", 32'(result.add_dropped), 32'(want.add_dropped));
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && item_ready) || (result_valid && result_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("timeout: no beat for %0d cycles", quiet_cycles);
                $display("tb NOT OK");
                $finish;
            end
        end
    end

    // 16 disjoint segments fill the store; then a lone add is dropped.
    task automatic test_fill_and_drop();
        for (int k = 0; k < CAPACITY - 1; k++)
            send_item(ius_pkg::ACT_ADD, k * 32'h100 + 32'h10, k * 32'h100 + 32'h18);
        send_item(ius_pkg::ACT_ADD, 32'hFFFF_FFF0, 32'hFFFF_FFFE);
        send_item(ius_pkg::ACT_ADD, 32'h2000, 32'h2004);
    endtask

    // Widest window: gap before, between and after every segment (17 beats).
    task automatic test_complement_full();
        send_item(ius_pkg::ACT_COMP, 32'h0, 32'hFFFF_FFFF);
    endtask

    // Touching add at full store still merges.
    task automatic test_merge_at_full();
        send_item(ius_pkg::ACT_ADD, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    endtask

    task automatic test_query_cases();
        send_item(ius_pkg::ACT_QUERY, 32'h14, 32'h14);     // empty range inside a segment
        send_item(ius_pkg::ACT_QUERY, 32'h100, 32'h200);   // segment lies wholly inside
        send_item(ius_pkg::ACT_QUERY, 32'h18, 32'h110);    // between two segments
        send_item(ius_pkg::ACT_QUERY, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
    endtask

    task automatic test_complement_edges();
        send_item(ius_pkg::ACT_COMP, 32'h500, 32'h400);    // reversed window
        send_item(ius_pkg::ACT_COMP, 32'h112, 32'h116);    // covered window
        send_item(ius_pkg::ACT_COMP, 32'h14, 32'h114);     // clipped on both sides
    endtask

    task automatic test_add_edges();
        send_item(ius_pkg::ACT_ADD, 32'h3000, 32'h3000);   // empty add
        send_item(ACT_NOP, 32'hFFFF_FFFF, 32'h0);
        send_item(ius_pkg::ACT_ADD, 32'h10, 32'hF18);      // swallows the low fifteen
    endtask

    // Windowed traffic per phase so segments collide, fill the store and merge.
    task automatic test_random_traffic();
        logic [FIELD_W-1:0] base, lo, hi;
        logic [1:0] act;
        int r;
        for (int ph = 1; ph <= 8; ph++)
        begin
            if (ph == 8)
                base = 32'hFFFF_FE00;
            else
                base = ph * 32'h1000_0000 + $urandom_range(0, 32'h0FFF_0000);
            idle_on    = (ph % 3) != 1;
            stall_mode = (ph == 1) ? 0 : ph % 4;
            for (int n = 0; n < 49; n++)
            begin
                r = $urandom_range(0, 99);
                if (r < 45)      act = ius_pkg::ACT_ADD;
                else if (r < 70) act = ius_pkg::ACT_QUERY;
                else if (r < 96) act = ius_pkg::ACT_COMP;
                else             act = ACT_NOP;
                if ($urandom_range(0, 9) == 0)
                    lo = $urandom;
                else
                    lo = base + $urandom_range(0, 320);
                if (act == ius_pkg::ACT_ADD)
                begin
                    if ($urandom_range(0, 9) == 0)
                        hi = lo - $urandom_range(0, 4);
                    else
                        hi = lo + $urandom_range(1, 24);
                end
                else
                begin
                    r = $urandom_range(0, 7);
                    if (r == 0)      hi = $urandom;
                    else if (r == 1) hi = lo - $urandom_range(0, 4);
                    else             hi = lo + $urandom_range(0, 90);
                end
                send_item(act, lo, hi);
            end
            // fold this window down to one segment to make room
            send_item(ius_pkg::ACT_ADD, base, base + 400);
        end
    endtask

    initial
    begin
        clk          = 1'b0;
        rst_n        = 1'b0;
        item_valid   = 1'b0;
        item         = '0;
        result_ready = 1'b0;
        seg_n        = 0;
        idle_on      = 1'b1;
        burst_left   = 0;
        stall_mode   = 2;
        stall_phase  = 0;
        quiet_cycles = 0;
        mismatches   = 0;
        items_sent   = 0;
        results_seen = 0;
        drops_seen   = 0;
        max_gaps     = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_fill_and_drop();
        test_complement_full();
        test_merge_at_full();
        test_query_cases();
        test_complement_edges();
        test_add_edges();
        test_random_traffic();

        item_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("ran %0d items through add/query/complement, %0d result beats checked",
                 items_sent, results_seen);
        $display("adds dropped on full store: %0d, most gaps from one window: %0d",
                 drops_seen, max_gaps);
        if (mismatches == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
